>>> rtl/nqse_pkg.sv
// shared types and constants for the n-queens enumerator
// no dependencies; used by nqse_ctrl, nqse_dp and the top level
package nqse_pkg;

  localparam int MAX_N_DEF  = 16;  // default largest board
  localparam int BOARD_W    = 5;   // board size register width
  localparam int COL_W      = 4;   // stored column / output column width
  localparam int SOL_W      = 24;  // solution counter width
  localparam logic [BOARD_W-1:0] BOARD_RST = 5'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEARCH,
    ST_EMIT,
    ST_NOTFOUND
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;     // input transfer, apply restart if requested
    logic step;       // one search step (place, advance or backtrack)
    logic fail;       // mark search exhausted
    logic emit_load;  // load one solution row into the output register
    logic nf_load;    // load the not-found result into the output register
  } nqse_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic dead;       // exhausted, or saved row beyond the board
    logic col_ge_n;   // no columns left in this row
    logic row_zero;   // searching the first row
    logic safe;       // candidate square not attacked
    logic row_last;   // searching the last row
    logic emit_last;  // emitting the last row
    logic out_free;   // output register can take a result this cycle
  } nqse_status_t;

endpackage

>>> rtl/nqse_ctrl.sv
// sequencer for the n-queens enumerator: accept, search, emit
// depends on nqse_pkg (state enum, command and status structs)
module nqse_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  nqse_pkg::nqse_status_t st_i,
  output nqse_pkg::nqse_cmd_t    cmd_o
);

  nqse_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nqse_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      nqse_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = nqse_pkg::ST_CHECK;
        end
      end
      nqse_pkg::ST_CHECK: begin
        if (st_i.dead) begin
          cmd_o.fail = 1'b1;
          state_d    = nqse_pkg::ST_NOTFOUND;
        end else begin
          state_d = nqse_pkg::ST_SEARCH;
        end
      end
      nqse_pkg::ST_SEARCH: begin
        if (st_i.col_ge_n && st_i.row_zero) begin
          cmd_o.fail = 1'b1;
          state_d    = nqse_pkg::ST_NOTFOUND;
        end else begin
          cmd_o.step = 1'b1;
          if (!st_i.col_ge_n && st_i.safe && st_i.row_last) begin
            state_d = nqse_pkg::ST_EMIT;
          end
        end
      end
      nqse_pkg::ST_EMIT: begin
        if (st_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          if (st_i.emit_last) begin
            state_d = nqse_pkg::ST_IDLE;
          end
        end
      end
      nqse_pkg::ST_NOTFOUND: begin
        if (st_i.out_free) begin
          cmd_o.nf_load = 1'b1;
          state_d       = nqse_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = nqse_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/nqse_dp.sv
// datapath: board size, column stack, safety lanes, counter, output register
// depends on nqse_pkg (widths, command and status structs)
module nqse_dp #(
  parameter int MAX_N = nqse_pkg::MAX_N_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [nqse_pkg::BOARD_W-1:0]      cfg_data_i,
  input  logic                              restart_i,
  input  nqse_pkg::nqse_cmd_t               cmd_i,
  output nqse_pkg::nqse_status_t            st_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [nqse_pkg::COL_W-1:0]        row_column_o,
  output logic                              found_o,
  output logic [nqse_pkg::SOL_W-1:0]        solution_index_o,
  output logic                              last_o
);

  localparam int CW  = $clog2(MAX_N + 1);  // row / column counter width
  localparam int IW  = $clog2(MAX_N);      // stack index width
  localparam int PW  = nqse_pkg::COL_W;
  localparam int BW  = nqse_pkg::BOARD_W;
  localparam int SW  = nqse_pkg::SOL_W;
  localparam logic [BW-1:0] MaxNB = BW'(MAX_N);

  logic [BW-1:0] board_q;
  logic [CW-1:0] n_eff, n_m1;
  logic [CW-1:0] row_q, row_d, col_q, col_d, row_m1;
  logic          started_q, started_d, exh_q, exh_d;
  logic [SW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] emit_q, emit_d, rd_idx;
  logic [PW-1:0] place_q [MAX_N];
  logic [PW-1:0] rd_col, col4, cand, dr, dc;
  logic          hit, place_we;

  logic          out_valid_q, out_valid_d;
  logic [PW-1:0] out_col_q;
  logic          out_found_q, out_last_q;
  logic [SW-1:0] out_idx_q;
  logic          out_load;

  // clamp board size into 1..MAX_N
  always_comb begin
    if (board_q == '0) begin
      n_eff = CW'(1);
    end else if (board_q > MaxNB) begin
      n_eff = CW'(MAX_N);
    end else begin
      n_eff = CW'(board_q);
    end
  end
  assign n_m1   = n_eff - CW'(1);
  assign row_m1 = row_q - CW'(1);
  assign col4   = PW'(col_q);

  // one lane per earlier row: column and diagonal check
  always_comb begin
    hit  = 1'b0;
    cand = '0;
    dr   = '0;
    dc   = '0;
    for (int i = 0; i < MAX_N; i++) begin
      if (CW'(i) < row_q) begin
        cand = place_q[i];
        dr   = PW'(row_q - CW'(i));
        dc   = (cand > col4) ? (cand - col4) : (col4 - cand);
        if ((cand == col4) || (dr == dc)) begin
          hit = 1'b1;
        end
      end
    end
  end

  // single read port: emit row, or the row above when backtracking
  assign rd_idx = cmd_i.emit_load ? emit_q : row_m1[IW-1:0];
  assign rd_col = place_q[rd_idx];

  assign st_o.dead      = exh_q || (row_q >= n_eff);
  assign st_o.col_ge_n  = (col_q >= n_eff);
  assign st_o.row_zero  = (row_q == '0);
  assign st_o.safe      = !hit;
  assign st_o.row_last  = (row_q == n_m1);
  assign st_o.emit_last = (CW'(emit_q) == n_m1);
  assign st_o.out_free  = !out_valid_q || out_ready_i;

  assign place_we = cmd_i.step && !st_o.col_ge_n && !hit;
  assign out_load = cmd_i.emit_load || cmd_i.nf_load;

  always_comb begin
    row_d     = row_q;
    col_d     = col_q;
    started_d = started_q;
    exh_d     = exh_q;
    cnt_d     = cnt_q;
    emit_d    = emit_q;
    if (cmd_i.accept && (restart_i || !started_q)) begin
      row_d     = '0;
      col_d     = '0;
      started_d = 1'b1;
      exh_d     = 1'b0;
      cnt_d     = '0;
    end
    if (cmd_i.fail) begin
      exh_d = 1'b1;
    end
    if (cmd_i.step) begin
      emit_d = '0;
      if (st_o.col_ge_n) begin
        row_d = row_m1;
        col_d = CW'({1'b0, rd_col} + {1'b0, PW'(1)});
      end else if (!hit) begin
        if (st_o.row_last) begin
          col_d = col_q + CW'(1);
        end else begin
          row_d = row_q + CW'(1);
          col_d = '0;
        end
      end else begin
        col_d = col_q + CW'(1);
      end
    end
    if (cmd_i.emit_load) begin
      emit_d = emit_q + IW'(1);
      if (st_o.emit_last) begin
        cnt_d = cnt_q + SW'(1);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_q     <= nqse_pkg::BOARD_RST;
      row_q       <= '0;
      col_q       <= '0;
      started_q   <= 1'b0;
      exh_q       <= 1'b0;
      cnt_q       <= '0;
      emit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        board_q <= cfg_data_i;
      end
      row_q       <= row_d;
      col_q       <= col_d;
      started_q   <= started_d;
      exh_q       <= exh_d;
      cnt_q       <= cnt_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // column stack and output payload, no reset
  always_ff @(posedge clk_i) begin
    if (place_we) begin
      place_q[row_q[IW-1:0]] <= col4;
    end
    if (out_load) begin
      out_col_q   <= cmd_i.emit_load ? rd_col : '0;
      out_found_q <= cmd_i.emit_load;
      out_last_q  <= cmd_i.nf_load || st_o.emit_last;
      out_idx_q   <= cnt_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign row_column_o     = out_col_q;
  assign found_o          = out_found_q;
  assign solution_index_o = out_idx_q;
  assign last_o           = out_last_q;

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten while holding a result");

  a_place_in_board: assert property (@(posedge clk_i) disable iff (!rst_ni)
    place_we |-> (row_q < n_eff) && (col_q < n_eff))
    else $error("queen placed outside the board");

  a_notfound_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.nf_load |=> out_valid_o && last_o && !found_o && (row_column_o == '0))
    else $error("not-found result malformed");

  a_count_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_load && st_o.emit_last) |=> (cnt_q == SW'($past(cnt_q) + SW'(1))))
    else $error("solution counter did not advance after last row");
`endif

endmodule

>>> rtl/n_queens_solution_enumerator_top.sv
// n-queens enumerator: per request, the next solution as n row results, or one not-found result
// sequence: accept, a check state, then search steps (place, advance or backtrack),
// then n results at one per cycle while the output register is free; next request
// accepted once the last result is loaded; the search loop takes a single step at a time
// reset: async active low; board size returns to 8, search state and counter cleared
// depends on nqse_pkg, nqse_ctrl and nqse_dp
module n_queens_solution_enumerator_top #(
  parameter int MAX_N = nqse_pkg::MAX_N_DEF  // largest board, 4..16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // board size register write
  input  logic                          cfg_we_i,
  input  logic [nqse_pkg::BOARD_W-1:0]  cfg_data_i,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          restart_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [nqse_pkg::COL_W-1:0]    row_column_o,
  output logic                          found_o,
  output logic [nqse_pkg::SOL_W-1:0]    solution_index_o,
  output logic                          last_o
);

  // command and status between the sequencer and the datapath
  nqse_pkg::nqse_cmd_t    cmd;
  nqse_pkg::nqse_status_t st;

  // sequencer: takes a request transfer only when idle, then walks the search
  // and hands rows to the output register as it frees up
  nqse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // datapath: column stack with parallel attack check, counter, and an
  // output register so a waiting result does not block the next request
  nqse_dp #(
    .MAX_N (MAX_N)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .restart_i        (restart_i),
    .cmd_i            (cmd),
    .st_o             (st),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .row_column_o     (row_column_o),
    .found_o          (found_o),
    .solution_index_o (solution_index_o),
    .last_o           (last_o)
  );

endmodule
